@@ design/rcd_pkg.sv @@
// shared types and constants for the rc4-drop keystream block
package rcd_pkg;

  localparam int SBOX_DEPTH    = 256;
  localparam int BYTE_W        = 8;
  localparam int KEY_WORDS     = 4;
  localparam int KEY_WORD_W    = 64;
  localparam int MAX_KEY_BYTES = 32;
  localparam int KEY_PTR_W     = 5;
  localparam int KEY_LEN_W     = 6;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH     = 3'd4;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

  localparam logic MODE_REKEY = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  // key byte lookup between config registers and the sequencer
  typedef struct packed {
    logic [BYTE_W-1:0]    key_byte;
    logic [KEY_PTR_W-1:0] len_last;
  } rcd_key_t;

  // start request from the handshake side
  typedef struct packed {
    logic start;
    logic rekey;
  } rcd_ctl_t;

  // sequencer status back to the handshake side
  typedef struct packed {
    logic              busy;
    logic              res_valid;
    logic [BYTE_W-1:0] ks;
  } rcd_sts_t;

endpackage

@@ design/rcd_ram.sv @@
// generic single write port ram with one registered read port
module rcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the contents from before a same-cycle write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/rcd_cfg.sv @@
// configuration registers, key byte selection and key length clamp
module rcd_cfg
  import rcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [KEY_WORD_W-1:0] cfg_wdata,
  input  logic [KEY_PTR_W-1:0]  key_ptr,
  output rcd_key_t              key
);

  logic [KEY_WORDS*KEY_WORD_W-1:0] key_r;
  logic [KEY_LEN_W-1:0]            key_len_r;
  logic [KEY_LEN_W-1:0]            len_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      key_len_r <= KEY_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_WORD_ZERO:  key_r[0*KEY_WORD_W +: KEY_WORD_W] <= cfg_wdata;
        REG_KEY_WORD_ONE:   key_r[1*KEY_WORD_W +: KEY_WORD_W] <= cfg_wdata;
        REG_KEY_WORD_TWO:   key_r[2*KEY_WORD_W +: KEY_WORD_W] <= cfg_wdata;
        REG_KEY_WORD_THREE: key_r[3*KEY_WORD_W +: KEY_WORD_W] <= cfg_wdata;
        REG_KEY_LENGTH:     key_len_r <= cfg_wdata[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = key_len_r;
    if (key_len_r == '0) begin
      len_eff = KEY_LEN_W'(1);
    end else if (key_len_r > KEY_LEN_W'(MAX_KEY_BYTES)) begin
      len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
    end
  end

  assign key.len_last = KEY_PTR_W'(len_eff - KEY_LEN_W'(1));
  assign key.key_byte = key_r[key_ptr*BYTE_W +: BYTE_W];

endmodule

@@ design/rcd_core.sv @@
// s-box sequencer: identity fill, key schedule and generator rounds
module rcd_core
  import rcd_pkg::*;
#(
  parameter int DROP_ROUNDS = 3072
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rcd_ctl_t             ctl,
  input  logic                 out_free,
  input  rcd_key_t             key,
  output logic [KEY_PTR_W-1:0] key_ptr,
  output rcd_sts_t             sts
);

  localparam int DW = (DROP_ROUNDS > 0) ? $clog2(DROP_ROUNDS + 1) : 1;

  localparam logic [3:0] ST_FILL = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_KA   = 4'd2;
  localparam logic [3:0] ST_KB   = 4'd3;
  localparam logic [3:0] ST_KC   = 4'd4;
  localparam logic [3:0] ST_KD   = 4'd5;
  localparam logic [3:0] ST_GA   = 4'd6;
  localparam logic [3:0] ST_GB   = 4'd7;
  localparam logic [3:0] ST_GC   = 4'd8;
  localparam logic [3:0] ST_GD   = 4'd9;
  localparam logic [3:0] ST_HOLD = 4'd10;

  logic [3:0]           state_r, state_nxt;
  logic [BYTE_W-1:0]    n_r, n_nxt;
  logic [BYTE_W-1:0]    i_r, i_nxt;
  logic [BYTE_W-1:0]    j_r, j_nxt;
  logic [KEY_PTR_W-1:0] kp_r, kp_nxt;
  logic [DW-1:0]        drop_r, drop_nxt;
  logic                 dropping_r, dropping_nxt;
  logic                 keying_r, keying_nxt;
  logic [BYTE_W-1:0]    si_r, si_nxt;
  logic [BYTE_W-1:0]    sj_r, sj_nxt;
  logic [BYTE_W-1:0]    t_r, t_nxt;
  logic [BYTE_W-1:0]    ks_r, ks_nxt;

  logic              we;
  logic [BYTE_W-1:0] waddr, wdata, raddr, rdata;
  logic [BYTE_W-1:0] ks_fwd;

  rcd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SBOX_DEPTH)
  ) u_sbox (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // the output read was issued alongside the first swap write, so patch it
  always_comb begin
    if (t_r == j_r) begin
      ks_fwd = si_r;
    end else if (t_r == i_r) begin
      ks_fwd = sj_r;
    end else begin
      ks_fwd = rdata;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    n_nxt        = n_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    kp_nxt       = kp_r;
    drop_nxt     = drop_r;
    dropping_nxt = dropping_r;
    keying_nxt   = keying_r;
    si_nxt       = si_r;
    sj_nxt       = sj_r;
    t_nxt        = t_r;
    ks_nxt       = ks_r;
    we           = 1'b0;
    waddr        = n_r;
    wdata        = n_r;
    raddr        = n_r;
    sts.busy      = (state_r != ST_IDLE);
    sts.res_valid = 1'b0;
    sts.ks        = ks_r;

    case (state_r)
      ST_FILL: begin
        we    = 1'b1;
        n_nxt = n_r + 8'd1;
        if (n_r == 8'hff) begin
          j_nxt  = '0;
          kp_nxt = '0;
          state_nxt = keying_r ? ST_KA : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (ctl.start) begin
          if (ctl.rekey) begin
            keying_nxt = 1'b1;
            n_nxt      = '0;
            state_nxt  = ST_FILL;
          end else begin
            dropping_nxt = 1'b0;
            state_nxt    = ST_GA;
          end
        end
      end
      ST_KA: begin
        raddr     = n_r;
        state_nxt = ST_KB;
      end
      ST_KB: begin
        si_nxt    = rdata;
        j_nxt     = j_r + rdata + key.key_byte;
        raddr     = j_nxt;
        state_nxt = ST_KC;
      end
      ST_KC: begin
        we        = 1'b1;
        waddr     = n_r;
        wdata     = rdata;
        state_nxt = ST_KD;
      end
      ST_KD: begin
        we     = 1'b1;
        waddr  = j_r;
        wdata  = si_r;
        kp_nxt = (kp_r == key.len_last) ? '0 : kp_r + KEY_PTR_W'(1);
        n_nxt  = n_r + 8'd1;
        state_nxt = ST_KA;
        if (n_r == 8'hff) begin
          i_nxt        = '0;
          j_nxt        = '0;
          keying_nxt   = 1'b0;
          dropping_nxt = 1'b1;
          drop_nxt     = DW'(DROP_ROUNDS);
          state_nxt    = (DROP_ROUNDS == 0) ? ST_IDLE : ST_GA;
        end
      end
      ST_GA: begin
        i_nxt     = i_r + 8'd1;
        raddr     = i_nxt;
        state_nxt = ST_GB;
      end
      ST_GB: begin
        si_nxt    = rdata;
        j_nxt     = j_r + rdata;
        raddr     = j_nxt;
        state_nxt = ST_GC;
      end
      ST_GC: begin
        sj_nxt    = rdata;
        we        = 1'b1;
        waddr     = i_r;
        wdata     = rdata;
        t_nxt     = si_r + rdata;
        raddr     = t_nxt;
        state_nxt = ST_GD;
      end
      ST_GD: begin
        we    = 1'b1;
        waddr = j_r;
        wdata = si_r;
        if (dropping_r) begin
          drop_nxt  = drop_r - DW'(1);
          state_nxt = (drop_r == DW'(1)) ? ST_IDLE : ST_GA;
        end else if (out_free) begin
          sts.res_valid = 1'b1;
          sts.ks        = ks_fwd;
          state_nxt     = ST_IDLE;
        end else begin
          ks_nxt    = ks_fwd;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          sts.res_valid = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FILL;
      n_r        <= '0;
      i_r        <= '0;
      j_r        <= '0;
      kp_r       <= '0;
      drop_r     <= '0;
      dropping_r <= 1'b0;
      keying_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      n_r        <= n_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      kp_r       <= kp_nxt;
      drop_r     <= drop_nxt;
      dropping_r <= dropping_nxt;
      keying_r   <= keying_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r <= si_nxt;
    sj_r <= sj_nxt;
    t_r  <= t_nxt;
    ks_r <= ks_nxt;
  end

  assign key_ptr = kp_r;

endmodule

@@ design/stream_cipher_drop_keystream.sv @@
// RC4 stream cipher with the first DROP_ROUNDS keystream bytes discarded after each
// rekey. The S-box lives in one 256 x 8 RAM with a single write port and one registered
// read port, and all work is sequenced through it. After reset the block loads the
// identity permutation and holds in_stall high meanwhile. A data transaction runs
// through the accepting cycle, read S[i], read S[j], first swap write with the output
// read, and second swap write before the next possible acceptance; its result is
// loaded into the output register at the second swap write, or later once the output
// register drains. A rekey transaction runs the identity reload, the key schedule and
// the drop rounds, and gives no result. The user must write the key registers through
// the cfg port only while the block is idle; the block itself does not enforce it.
module stream_cipher_drop_keystream
  import rcd_pkg::*;
#(
  parameter int DROP_ROUNDS = 3072
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [KEY_WORD_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic [BYTE_W-1:0]     in_data_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_cipher_byte,
  output logic [BYTE_W-1:0]     out_keystream_byte
);

  rcd_key_t             key;
  rcd_ctl_t             ctl;
  rcd_sts_t             sts;
  logic [KEY_PTR_W-1:0] key_ptr;
  logic                 in_accept;
  logic                 out_free;
  logic                 out_valid_r;
  logic [BYTE_W-1:0]    data_r;
  logic [BYTE_W-1:0]    cipher_r;
  logic [BYTE_W-1:0]    ks_out_r;

  rcd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .key_ptr   (key_ptr),
    .key       (key)
  );

  rcd_core #(
    .DROP_ROUNDS (DROP_ROUNDS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .out_free (out_free),
    .key      (key),
    .key_ptr  (key_ptr),
    .sts      (sts)
  );

  assign in_stall  = sts.busy;
  assign in_accept = in_valid && !in_stall;
  assign ctl.start = in_accept;
  assign ctl.rekey = (in_mode == MODE_REKEY);
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sts.res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // plaintext is held from the accepting transaction until its keystream byte is ready
  always_ff @(posedge clk) begin
    if (in_accept) begin
      data_r <= in_data_byte;
    end
    if (sts.res_valid) begin
      cipher_r <= data_r ^ sts.ks;
      ks_out_r <= sts.ks;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cipher_byte    = cipher_r;
  assign out_keystream_byte = ks_out_r;

endmodule

@@ tb/sv/stream_cipher_drop_keystream_tb.sv @@
// self-checking testbench for the rc4-drop keystream block
`timescale 1ns / 1ps

module stream_cipher_drop_keystream_tb;
  import rcd_pkg::*;

  localparam int DROP_ROUNDS    = 3072;
  localparam int REKEY_CYCLES   = 1 + SBOX_DEPTH + 4 * SBOX_DEPTH + 4 * DROP_ROUNDS + 64;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4 * REKEY_CYCLES;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 385;

  typedef struct {
    logic              mode;
    logic [BYTE_W-1:0] data;
  } cipher_item_t;

  typedef struct {
    logic [BYTE_W-1:0] cipher;
    logic [BYTE_W-1:0] ks;
  } cipher_result_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [KEY_WORD_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic                  in_mode      = MODE_DATA;
  logic [BYTE_W-1:0]     in_data_byte = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [BYTE_W-1:0]     out_cipher_byte;
  logic [BYTE_W-1:0]     out_keystream_byte;

  stream_cipher_drop_keystream #(
    .DROP_ROUNDS(DROP_ROUNDS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cipher_byte    (out_cipher_byte),
    .out_keystream_byte (out_keystream_byte)
  );

  always #10 clk = ~clk;

  // predictor state: permutation, indices and a shadow of the key registers
  logic [BYTE_W-1:0]     sbox_model [SBOX_DEPTH];
  logic [BYTE_W-1:0]     ptr_i;
  logic [BYTE_W-1:0]     ptr_j;
  logic [KEY_WORD_W-1:0] key_shadow [KEY_WORDS];
  logic [KEY_LEN_W-1:0]  key_len_shadow;

  cipher_item_t   plaintext_q [$];
  cipher_result_t cipher_expect_q [$];
  cipher_item_t   next_item;
  int             pushed_count   = 0;
  int             accepted_count = 0;
  int             error_count    = 0;
  int             idle_cycles    = 0;
  logic           last_mode      = MODE_DATA;
  bit             calm           = 1'b0;

  function automatic void rc4_swap(int a, int b);
    logic [BYTE_W-1:0] t;
    t             = sbox_model[a];
    sbox_model[a] = sbox_model[b];
    sbox_model[b] = t;
  endfunction

  function automatic logic [BYTE_W-1:0] rc4_next_keystream();
    logic [BYTE_W-1:0] sum;
    ptr_i = ptr_i + 8'd1;
    ptr_j = ptr_j + sbox_model[ptr_i];
    rc4_swap(ptr_i, ptr_j);
    sum = sbox_model[ptr_i] + sbox_model[ptr_j];
    return sbox_model[sum];
  endfunction

  function automatic void rc4_rekey();
    int                len;
    int                k;
    logic [BYTE_W-1:0] j;
    logic [BYTE_W-1:0] kb;
    logic [BYTE_W-1:0] discard;
    len = key_len_shadow;
    // out-of-range lengths are clamped to 1..32
    if (len == 0) len = 1;
    if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
    for (int n = 0; n < SBOX_DEPTH; n++) sbox_model[n] = BYTE_W'(n);
    j = '0;
    for (int n = 0; n < SBOX_DEPTH; n++) begin
      k  = n % len;
      kb = key_shadow[k >> 3][(k & 7) * 8 +: 8];
      j  = j + sbox_model[n] + kb;
      rc4_swap(n, j);
    end
    ptr_i = '0;
    ptr_j = '0;
    for (int n = 0; n < DROP_ROUNDS; n++) discard = rc4_next_keystream();
  endfunction

  function automatic void rc4_predict(logic mode, logic [BYTE_W-1:0] data);
    cipher_result_t r;
    if (mode == MODE_REKEY) begin
      rc4_rekey();
    end else begin
      r.ks     = rc4_next_keystream();
      r.cipher = data ^ r.ks;
      cipher_expect_q.push_back(r);
    end
  endfunction

  // driver: presents queued transactions, predicts each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rc4_predict(in_mode, in_data_byte);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (plaintext_q.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
          next_item = plaintext_q.pop_front();
          in_valid     <= 1'b1;
          in_mode      <= next_item.mode;
          in_data_byte <= next_item.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 9);
    end
  end

  // monitor
  always @(posedge clk) begin
    cipher_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual cipher %h keystream %h",
                 $time, out_cipher_byte, out_keystream_byte);
        error_count++;
      end else begin
        exp_r = cipher_expect_q.pop_front();
        if (out_cipher_byte !== exp_r.cipher) begin
          $display("%0t: cipher_byte expected %h actual %h",
                   $time, exp_r.cipher, out_cipher_byte);
          error_count++;
        end
        if (out_keystream_byte !== exp_r.ks) begin
          $display("%0t: keystream_byte expected %h actual %h",
                   $time, exp_r.ks, out_keystream_byte);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall)) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  task automatic queue_item(input logic mode, input logic [BYTE_W-1:0] data);
    cipher_item_t it;
    it.mode = mode;
    it.data = data;
    plaintext_q.push_back(it);
    pushed_count++;
    last_mode = mode;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [KEY_WORD_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx < KEY_WORDS) key_shadow[idx] = value;
    else if (idx == REG_KEY_LENGTH) key_len_shadow = value[KEY_LEN_W-1:0];
  endtask

  task automatic load_key(input logic [KEY_WORD_W-1:0] w0, input logic [KEY_WORD_W-1:0] w1,
                          input logic [KEY_WORD_W-1:0] w2, input logic [KEY_WORD_W-1:0] w3,
                          input logic [KEY_LEN_W-1:0] len, input bit stray);
    write_reg(REG_KEY_WORD_ZERO, w0);
    write_reg(REG_KEY_WORD_ONE, w1);
    write_reg(REG_KEY_WORD_TWO, w2);
    write_reg(REG_KEY_WORD_THREE, w3);
    write_reg(REG_KEY_LENGTH, KEY_WORD_W'(len));
    // indexes past the register list must be ignored
    if (stray) begin
      for (int r = REG_KEY_LENGTH + 1; r < (1 << CFG_IDX_W); r++)
        write_reg(CFG_IDX_W'(r), {$urandom, $urandom});
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (accepted_count != pushed_count || cipher_expect_q.size() != 0) @(posedge clk);
    // a trailing rekey yields nothing, so give it time to finish
    repeat (last_mode == MODE_REKEY ? REKEY_CYCLES : SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [KEY_WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_LEN_W-1:0] rand_key_len();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return KEY_LEN_W'($urandom_range(63, MAX_KEY_BYTES + 1));
    return KEY_LEN_W'($urandom_range(MAX_KEY_BYTES, 1));
  endfunction

  task automatic random_items(input int count);
    logic mode;
    for (int n = 0; n < count; n++) begin
      mode = ($urandom_range(99) == 0) ? MODE_REKEY : MODE_DATA;
      if (n == 0 && $urandom_range(3) != 0) mode = MODE_REKEY;
      // finish on data so that the phase boundary is observable
      if (n == count - 1) mode = MODE_DATA;
      queue_item(mode, BYTE_W'($urandom_range(255)));
    end
  endtask

  initial begin
    for (int n = 0; n < SBOX_DEPTH; n++) sbox_model[n] = BYTE_W'(n);
    ptr_i = '0;
    ptr_j = '0;
    for (int w = 0; w < KEY_WORDS; w++) key_shadow[w] = '0;
    key_len_shadow = KEY_LEN_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // data on the reset permutation, then a rekey with the reset key
    queue_item(MODE_DATA, 8'h00);
    queue_item(MODE_DATA, 8'hFF);
    queue_item(MODE_DATA, 8'h5A);
    queue_item(MODE_REKEY, 8'hFF);
    queue_item(MODE_DATA, 8'h00);
    queue_item(MODE_DATA, 8'hFF);
    queue_item(MODE_DATA, 8'hA5);
    wait_idle();

    // all-ones key at full length, back-to-back rekeys
    load_key('1, '1, '1, '1, KEY_LEN_W'(MAX_KEY_BYTES), 1'b1);
    queue_item(MODE_REKEY, 8'h00);
    queue_item(MODE_REKEY, 8'h81);
    queue_item(MODE_DATA, 8'h00);
    queue_item(MODE_DATA, 8'hFF);
    queue_item(MODE_DATA, 8'h3C);
    wait_idle();

    // single-byte key
    load_key(rand_word(), '0, '0, '0, KEY_LEN_W'(1), 1'b0);
    queue_item(MODE_REKEY, 8'h7E);
    queue_item(MODE_DATA, 8'h01);
    queue_item(MODE_DATA, 8'h80);
    wait_idle();

    // zero length behaves as one byte
    load_key(rand_word(), rand_word(), rand_word(), rand_word(), '0, 1'b0);
    queue_item(MODE_REKEY, 8'h00);
    queue_item(MODE_DATA, 8'h55);
    queue_item(MODE_DATA, 8'hAA);
    wait_idle();

    // largest encodable length clamps to the maximum
    load_key(rand_word(), rand_word(), rand_word(), rand_word(), '1, 1'b0);
    queue_item(MODE_REKEY, 8'hC3);
    queue_item(MODE_DATA, 8'h0F);
    queue_item(MODE_DATA, 8'hF0);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p == 2);
      load_key(rand_word(), rand_word(), rand_word(), rand_word(), rand_key_len(), p == 1);
      random_items(PHASE_ITEMS);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
